// ===== rtl/frb_pkg.sv =====
// ----------------------------------------------------------------------------
// frb_pkg
// Shared types, status codes and helpers for the frame ring buffer.
// ----------------------------------------------------------------------------
package frb_pkg;

  // Store geometry
  localparam int MEM_BYTES = 4096;
  localparam int MAX_SLOTS = 256;
  localparam int MAX_FRAME = 64;
  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int POS_W     = $clog2(MAX_FRAME);

  // Output queue
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // Commands
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // Result status codes
  localparam logic [2:0] STS_TAKEN   = 3'd0;
  localparam logic [2:0] STS_COMMIT  = 3'd1;
  localparam logic [2:0] STS_DROP    = 3'd2;
  localparam logic [2:0] STS_POPPED  = 3'd3;
  localparam logic [2:0] STS_EMPTY   = 3'd4;
  localparam logic [2:0] STS_CLEARED = 3'd5;
  localparam logic [2:0] STS_CFGERR  = 3'd6;

  // Configuration register indexes
  localparam logic CFG_SLOT_COUNT  = 1'b0;
  localparam logic CFG_FRAME_BYTES = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] read_byte;
    logic       last;
    logic [7:0] frames_held;
  } out_item_t;

  typedef struct packed {
    logic [8:0] slot_count;
    logic [6:0] frame_bytes;
    logic       ok;
  } cfg_t;

  // Committed frames between read and write slot
  function automatic logic [7:0] held_of(input logic [7:0] ws, input logic [7:0] rs,
                                         input logic [8:0] sc);
    logic [8:0] diff;
    if (ws >= rs) begin
      diff = {1'b0, ws} - {1'b0, rs};
    end else begin
      diff = {1'b0, ws} + sc - {1'b0, rs};
    end
    return diff[7:0];
  endfunction

endpackage

// ===== rtl/frb_ram.sv =====
// ----------------------------------------------------------------------------
// frb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module frb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/frb_outq.sv =====
// ----------------------------------------------------------------------------
// frb_outq
// Small result queue between the control logic and the output channel.
// ----------------------------------------------------------------------------
module frb_outq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  frb_pkg::out_item_t        item_i,
  output logic [frb_pkg::OQ_CNT_W-1:0] count_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output frb_pkg::out_item_t        out_item_o
);
  import frb_pkg::*;

  out_item_t             buf_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   head_q, head_d;
  logic [OQ_PTR_W-1:0]   tail_q, tail_d;
  logic [OQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  deq;

  assign deq         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_item_o  = buf_q[head_q];
  assign count_o     = cnt_q;

  // Pointer and fill count update
  always_comb begin
    head_d = deq    ? head_q + 1'b1 : head_q;
    tail_d = push_i ? tail_q + 1'b1 : tail_q;
    cnt_d  = cnt_q;
    if (push_i && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  // Entry storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[tail_q] <= item_i;
    end
  end

endmodule

// ===== rtl/frb_ctrl.sv =====
// ----------------------------------------------------------------------------
// frb_ctrl
// Slot pointers, push/pop/clear handling and frame read sequencing.
// ----------------------------------------------------------------------------
module frb_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  frb_pkg::cfg_t                cfg_i,
  input  logic                         cfg_clr_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  frb_pkg::in_item_t            in_item_i,
  input  logic [frb_pkg::OQ_CNT_W-1:0] oq_count_i,
  output logic                         res_push_o,
  output frb_pkg::out_item_t           res_item_o,
  output logic                         ram_we_o,
  output logic [frb_pkg::ADDR_W-1:0]   ram_waddr_o,
  output logic [7:0]                   ram_wdata_o,
  output logic                         ram_re_o,
  output logic [frb_pkg::ADDR_W-1:0]   ram_raddr_o,
  input  logic [7:0]                   ram_rdata_i
);
  import frb_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic              state_q, state_d;
  logic [7:0]        ws_q, ws_d;
  logic [7:0]        rs_q, rs_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              drop_q, drop_d;
  logic [ADDR_W-1:0] wbase_q, wbase_d;
  logic [ADDR_W-1:0] rbase_q, rbase_d;
  logic [POS_W-1:0]  idx_q, idx_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;

  logic              accept;
  logic              issue;
  logic              issue_last;
  logic [8:0]        ws_inc, ws_nx, rs_inc, rs_nx;
  logic              ws_wrap, rs_wrap;
  logic              drop_now;
  logic [POS_W:0]    pos_inc;
  logic              frame_done;
  logic [ADDR_W-1:0] fb_a;
  logic [OQ_CNT_W:0] q_used;

  assign fb_a = ADDR_W'(cfg_i.frame_bytes);

  // Items enter only when idle with no read in flight and queue room
  assign in_ready_o = (state_q == S_IDLE) && !pend_q && (oq_count_i < OQ_CNT_W'(OQ_DEPTH));
  assign accept     = in_valid_i && in_ready_o;

  // Issue a frame read only when its result has a queue entry reserved
  assign q_used     = {1'b0, oq_count_i} + {{OQ_CNT_W{1'b0}}, pend_q};
  assign issue      = (state_q == S_POP) && (q_used < (OQ_CNT_W+1)'(OQ_DEPTH));
  assign issue_last = ({1'b0, idx_q} == (cfg_i.frame_bytes - 7'd1));

  // Slot increments with wrap at slot_count
  assign ws_inc  = {1'b0, ws_q} + 9'd1;
  assign ws_wrap = (ws_inc == cfg_i.slot_count);
  assign ws_nx   = ws_wrap ? 9'd0 : ws_inc;
  assign rs_inc  = {1'b0, rs_q} + 9'd1;
  assign rs_wrap = (rs_inc == cfg_i.slot_count);
  assign rs_nx   = rs_wrap ? 9'd0 : rs_inc;

  // Drop decision is taken on the first byte of a frame
  assign drop_now   = (pos_q == '0) ? (ws_nx == {1'b0, rs_q}) : drop_q;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;
  assign frame_done = ((POS_W+1)'(pos_inc) >= (POS_W+1)'(cfg_i.frame_bytes));

  // Store access
  assign ram_we_o    = accept && cfg_i.ok && (in_item_i.command == CMD_PUSH) && !drop_now;
  assign ram_waddr_o = wbase_q + ADDR_W'(pos_q);
  assign ram_wdata_o = in_item_i.data_byte;
  assign ram_re_o    = issue;
  assign ram_raddr_o = rbase_q + ADDR_W'(idx_q);

  // Next state and result generation
  always_comb begin
    state_d     = state_q;
    ws_d        = ws_q;
    rs_d        = rs_q;
    pos_d       = pos_q;
    drop_d      = drop_q;
    wbase_d     = wbase_q;
    rbase_d     = rbase_q;
    idx_d       = idx_q;
    pend_d      = issue;
    pend_last_d = issue_last;
    res_push_o  = 1'b0;
    res_item_o  = '0;

    // Frame byte coming back from the store
    if (pend_q) begin
      res_push_o             = 1'b1;
      res_item_o.status      = STS_POPPED;
      res_item_o.read_byte   = ram_rdata_i;
      res_item_o.last        = pend_last_q;
      res_item_o.frames_held = held_of(ws_q, rs_q, cfg_i.slot_count);
    end

    // Read sequencing; the frame leaves the ring with its final read
    if (issue) begin
      if (issue_last) begin
        state_d = S_IDLE;
        idx_d   = '0;
        rs_d    = rs_nx[7:0];
        rbase_d = rs_wrap ? '0 : rbase_q + fb_a;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end

    if (accept) begin
      res_item_o.last = 1'b1;
      if (!cfg_i.ok) begin
        res_push_o        = (in_item_i.command != CMD_NONE);
        res_item_o.status = STS_CFGERR;
      end else begin
        unique case (in_item_i.command)
          CMD_PUSH: begin
            res_push_o = 1'b1;
            if (frame_done) begin
              pos_d  = '0;
              drop_d = 1'b0;
              if (drop_now) begin
                res_item_o.status = STS_DROP;
              end else begin
                ws_d              = ws_nx[7:0];
                wbase_d           = ws_wrap ? '0 : wbase_q + fb_a;
                res_item_o.status = STS_COMMIT;
              end
            end else begin
              pos_d             = pos_inc[POS_W-1:0];
              drop_d            = drop_now;
              res_item_o.status = drop_now ? STS_DROP : STS_TAKEN;
            end
            res_item_o.frames_held = held_of(ws_d, rs_q, cfg_i.slot_count);
          end
          CMD_POP: begin
            if (rs_q == ws_q) begin
              res_push_o        = 1'b1;
              res_item_o.status = STS_EMPTY;
            end else begin
              state_d = S_POP;
              idx_d   = '0;
            end
          end
          CMD_CLEAR: begin
            res_push_o        = 1'b1;
            res_item_o.status = STS_CLEARED;
            ws_d              = '0;
            rs_d              = '0;
            pos_d             = '0;
            drop_d            = 1'b0;
            wbase_d           = '0;
            rbase_d           = '0;
          end
          CMD_NONE: begin
            res_push_o = 1'b0;
          end
          default: begin
            res_push_o = 1'b0;
          end
        endcase
      end
    end

    // Any register write empties the ring
    if (cfg_clr_i) begin
      ws_d    = '0;
      rs_d    = '0;
      pos_d   = '0;
      drop_d  = 1'b0;
      wbase_d = '0;
      rbase_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ws_q        <= '0;
      rs_q        <= '0;
      pos_q       <= '0;
      drop_q      <= 1'b0;
      wbase_q     <= '0;
      rbase_q     <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      pend_last_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ws_q        <= ws_d;
      rs_q        <= rs_d;
      pos_q       <= pos_d;
      drop_q      <= drop_d;
      wbase_q     <= wbase_d;
      rbase_q     <= rbase_d;
      idx_q       <= idx_d;
      pend_q      <= pend_d;
      pend_last_q <= pend_last_d;
    end
  end

endmodule

// ===== rtl/frame_ring_buffer.sv =====
// Push, clear, empty and config-error results enter the result queue in the accepting cycle.
// Push requests are taken one per cycle while the result queue has room.
// A pop holds the input from its accepting cycle through one store read per byte, each
// waiting for a free result queue entry, and the registered read of its final byte.
// Reset: slot_count and frame_bytes return to 16, the ring is empty; store contents
// stay undefined and need no clearing pass.
// ----------------------------------------------------------------------------
// frame_ring_buffer
// Byte FIFO of fixed-size frames held in a ring of slots in a byte store.
// ----------------------------------------------------------------------------
module frame_ring_buffer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  frb_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output frb_pkg::out_item_t  out_item_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [8:0]          cfg_data_i
);
  import frb_pkg::*;

  logic [8:0]          slot_count_q, slot_count_d;
  logic [6:0]          frame_bytes_q, frame_bytes_d;
  logic [16:0]         geom_prod;
  cfg_t                cfg;
  logic                res_push;
  out_item_t           res_item;
  logic [OQ_CNT_W-1:0] oq_count;
  logic                ram_we, ram_re;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;

  // Configuration registers
  always_comb begin
    slot_count_d  = slot_count_q;
    frame_bytes_d = frame_bytes_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SLOT_COUNT:  slot_count_d  = cfg_data_i;
        CFG_FRAME_BYTES: frame_bytes_d = cfg_data_i[6:0];
        default:         slot_count_d  = slot_count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q  <= 9'd16;
      frame_bytes_q <= 7'd16;
    end else begin
      slot_count_q  <= slot_count_d;
      frame_bytes_q <= frame_bytes_d;
    end
  end

  // Geometry check
  assign geom_prod = {8'b0, slot_count_q} * {10'b0, frame_bytes_q};

  always_comb begin
    cfg.slot_count  = slot_count_q;
    cfg.frame_bytes = frame_bytes_q;
    cfg.ok          = (slot_count_q != '0) && (frame_bytes_q != '0)
                      && ({23'b0, slot_count_q} <= 32'(MAX_SLOTS))
                      && ({25'b0, frame_bytes_q} <= 32'(MAX_FRAME))
                      && ({15'b0, geom_prod} <= 32'(MEM_BYTES));
  end

  frb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_clr_i   (cfg_we_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .oq_count_i  (oq_count),
    .res_push_o  (res_push),
    .res_item_o  (res_item),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  frb_ram #(
    .WIDTH (8),
    .DEPTH (MEM_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  frb_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .item_i      (res_item),
    .count_o     (oq_count),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/frb_checker.sv =====
// ----------------------------------------------------------------------------
// frb_checker
// Port-level checks on the frame ring buffer results.
// ----------------------------------------------------------------------------
module frb_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                out_valid_o,
  input  logic                out_ready_i,
  input  frb_pkg::out_item_t  out_item_o
);
  import frb_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // Only frame bytes of a pop continue past one result
  a_last_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> out_item_o.status == STS_POPPED)
    else $error("non-final result that is not a popped byte");

  // Read byte is zero outside pops
  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != STS_POPPED |-> out_item_o.read_byte == 8'd0)
    else $error("read byte set on a non-pop result");

  // Empty, cleared and error results report no frames held
  a_held_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == STS_EMPTY || out_item_o.status == STS_CLEARED
                    || out_item_o.status == STS_CFGERR)
    |-> out_item_o.frames_held == 8'd0)
    else $error("frames held non-zero on empty ring result");

endmodule

bind frame_ring_buffer frb_checker u_frb_checker (.*);

// ===== verif/frame_ring_buffer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_ring_buffer_tb
// Drives byte pushes, frame pops, clears and unused commands into the frame
// ring buffer under several ring geometries, including bad ones. A shadow of
// the slot ring predicts every result. The monitor checks each one in order.
// ----------------------------------------------------------------------------
module frame_ring_buffer_tb;
  import frb_pkg::*;

  localparam int LIMIT       = 2_000_000;
  localparam int SETTLE      = 2 * MAX_FRAME + 8;
  localparam int HOLD_CYCLES = 200;
  localparam int RAND_BUDGET = 4;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  in_item_t   in_item_i   = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we_i    = 1'b0;
  logic       cfg_idx_i   = 1'b0;
  logic [8:0] cfg_data_i  = '0;

  frame_ring_buffer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Requests waiting to be sent, results waiting to arrive
  in_item_t  pending_items[$];
  out_item_t results_due[$];

  // Shadow of the ring
  logic [7:0] shadow_store [MEM_BYTES];
  int         ring_slots = 16;
  int         ring_frame = 16;
  int         wr_slot    = 0;
  int         rd_slot    = 0;
  int         fill_pos   = 0;
  bit         discarding = 1'b0;

  int mismatches    = 0;
  int cycles        = 0;
  int send_gap      = 0;
  int stall_left    = 0;
  int hold_left     = 0;
  int hold_requests = 0;
  int hold_seen     = 0;
  bit steady_in     = 1'b0;
  bit steady_out    = 1'b0;

  // Mostly short gaps, a few long ones; none in steady mode
  function automatic int idle_len(input bit steady);
    int p;
    p = $urandom_range(0, 99);
    if (steady || p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic logic [7:0] frames_queued();
    return 8'((wr_slot + ring_slots - rd_slot) % ring_slots);
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(input int slot, input int pos);
    int a;
    a = slot * ring_frame + pos;
    return ADDR_W'((a < MEM_BYTES) ? a : 0);
  endfunction

  function automatic void empty_ring();
    wr_slot    = 0;
    rd_slot    = 0;
    fill_pos   = 0;
    discarding = 1'b0;
  endfunction

  // Work out the results of one accepted request and queue them
  function automatic void ring_response(input in_item_t req);
    out_item_t r;
    int        i;
    if (req.command == CMD_NONE) return;
    r = '0;
    r.last = 1'b1;
    if (ring_slots == 0 || ring_frame == 0 || ring_slots > MAX_SLOTS ||
        ring_frame > MAX_FRAME || ring_slots * ring_frame > MEM_BYTES) begin
      r.status = STS_CFGERR;
      results_due.push_back(r);
      return;
    end
    case (req.command)
      CMD_CLEAR: begin
        empty_ring();
        r.status = STS_CLEARED;
        results_due.push_back(r);
      end
      CMD_PUSH: begin
        // Ring fullness is decided on the first byte of a frame
        if (fill_pos == 0) discarding = ((wr_slot + 1) % ring_slots) == rd_slot;
        if (!discarding) shadow_store[slot_addr(wr_slot, fill_pos)] = req.data_byte;
        fill_pos++;
        if (fill_pos >= ring_frame) begin
          fill_pos = 0;
          if (discarding) begin
            r.status = STS_DROP;
          end else begin
            wr_slot  = (wr_slot + 1) % ring_slots;
            r.status = STS_COMMIT;
          end
          discarding = 1'b0;
        end else begin
          r.status = discarding ? STS_DROP : STS_TAKEN;
        end
        r.frames_held = frames_queued();
        results_due.push_back(r);
      end
      default: begin
        if (rd_slot == wr_slot) begin
          r.status      = STS_EMPTY;
          r.frames_held = frames_queued();
          results_due.push_back(r);
        end else begin
          // Frame still counted until its final byte leaves
          r.status      = STS_POPPED;
          r.last        = 1'b0;
          r.frames_held = frames_queued();
          for (i = 0; i + 1 < ring_frame; i++) begin
            r.read_byte = shadow_store[slot_addr(rd_slot, i)];
            results_due.push_back(r);
          end
          r.read_byte   = shadow_store[slot_addr(rd_slot, i)];
          rd_slot       = (rd_slot + 1) % ring_slots;
          r.last        = 1'b1;
          r.frames_held = frames_queued();
          results_due.push_back(r);
        end
      end
    endcase
  endfunction

  // Sender: one request in flight, held until taken
  always @(posedge clk_i) begin : sender
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) ring_response(in_item_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap   <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item_i  <= pending_items.pop_front();
          in_valid_i <= 1'b1;
          send_gap   <= idle_len(steady_in);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles
  always @(posedge clk_i) begin : hold_off
    if (rst_ni) begin
      if (hold_seen != hold_requests) begin
        hold_seen <= hold_requests;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Receiver: checks results in order and throttles out_ready_i
  always @(posedge clk_i) begin : receiver
    out_item_t want;
    int        gap;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] unexpected result: status %0d byte %02h last %0b held %0d",
                     $realtime, out_item_o.status, out_item_o.read_byte,
                     out_item_o.last, out_item_o.frames_held);
        end else begin
          want = results_due.pop_front();
          if (out_item_o.status !== want.status || out_item_o.read_byte !== want.read_byte ||
              out_item_o.last !== want.last || out_item_o.frames_held !== want.frames_held)
          begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: exp status %0d byte %02h last %0b held %0d, %s",
                       $realtime, want.status, want.read_byte, want.last, want.frames_held,
                       $sformatf("got status %0d byte %02h last %0b held %0d",
                                 out_item_o.status, out_item_o.read_byte,
                                 out_item_o.last, out_item_o.frames_held));
          end
        end
      end
      // Long hold-off first, then ordinary random stalls
      if (hold_seen != hold_requests || hold_left > 0) begin
        out_ready_i <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left  <= stall_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        gap = idle_len(steady_out);
        if (gap == 0) begin
          out_ready_i <= 1'b1;
        end else begin
          stall_left  <= gap - 1;
          out_ready_i <= 1'b0;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] cmd, input logic [7:0] data);
    in_item_t req;
    req.command   = cmd;
    req.data_byte = data;
    pending_items.push_back(req);
  endtask

  task automatic queue_frame(input int count);
    repeat (count) queue_item(CMD_PUSH, 8'($urandom_range(0, 255)));
  endtask

  // Wait until everything sent has been answered, plus the pop latency
  task automatic settle();
    @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || results_due.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SLOT_COUNT) ring_slots = int'(val);
    else ring_frame = int'(val[6:0]);
    empty_ring();
  endtask

  task automatic set_ring(input logic [8:0] slots, input logic [8:0] fbytes);
    settle();
    write_reg(CFG_SLOT_COUNT, slots);
    write_reg(CFG_FRAME_BYTES, fbytes);
  endtask

  // Whole frames with random content, partial frames, pops, clears and noise
  task automatic random_traffic(input int budget);
    int n;
    int p;
    int k;
    n = 0;
    while (n < budget) begin
      p = $urandom_range(0, 99);
      if (p < 45) begin
        queue_frame(ring_frame);
        n += ring_frame;
      end else if (p < 75) begin
        queue_item(CMD_POP, 8'($urandom_range(0, 255)));
        n++;
      end else if (p < 82) begin
        queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        n++;
      end else if (p < 90) begin
        queue_item(CMD_NONE, 8'($urandom_range(0, 255)));
      end else begin
        k = $urandom_range(1, ring_frame);
        queue_frame(k);
        n += k;
      end
    end
  endtask

  initial begin : stimulus
    int bad_slots [6];
    int bad_frame [6];
    int rnd_slots [6];
    int rnd_frame [6];
    int i;

    bad_slots = '{0, 16, 257, 511, 8, 128};
    bad_frame = '{16, 0, 4, 127, 65, 64};
    rnd_slots = '{3, 4, 2, 5, 1, 7};
    rnd_frame = '{1, 3, 2, 4, 2, 5};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: empty pop, ignored command, clear
    queue_item(CMD_POP, 8'h00);
    queue_item(CMD_NONE, 8'hFF);
    queue_item(CMD_CLEAR, 8'hFF);

    // Two slots hold one frame: second frame is dropped, partial frame unseen
    set_ring(9'd2, 9'd2);
    queue_item(CMD_PUSH, 8'hFF);
    queue_item(CMD_PUSH, 8'h00);
    queue_frame(2);
    queue_item(CMD_POP, 8'h00);
    queue_item(CMD_PUSH, 8'h5A);
    queue_item(CMD_POP, 8'h00);
    queue_item(CMD_CLEAR, 8'h00);
    queue_item(CMD_POP, 8'h00);

    // Single slot: everything dropped
    set_ring(9'd1, 9'd3);
    queue_frame(3);
    queue_item(CMD_POP, 8'h00);

    // Largest frame fills the whole store; then many one-byte slots
    set_ring(9'd64, 9'd64);
    queue_frame(64);
    queue_item(CMD_POP, 8'h00);
    set_ring(9'd256, 9'd1);
    queue_frame(3);
    repeat (2) queue_item(CMD_POP, 8'h00);

    // Bad geometries: every push, pop and clear reports a config error
    for (i = 0; i < 6; i++) begin
      set_ring(9'(bad_slots[i]), 9'(bad_frame[i]));
      queue_item((i % 2 == 0) ? CMD_PUSH : CMD_POP, 8'($urandom_range(0, 255)));
      queue_item(CMD_CLEAR, 8'h00);
      if (i == 0) queue_item(CMD_NONE, 8'h00);
    end

    // Random traffic over small rings; one phase with a long receiver hold-off
    for (i = 0; i < 6; i++) begin
      set_ring(9'(rnd_slots[i]), 9'(rnd_frame[i]));
      steady_in  = (i % 3 == 0);
      steady_out = (i % 3 == 1);
      if (i == 1) begin
        hold_requests++;
        queue_frame(2 * ring_frame);
      end
      random_traffic(RAND_BUDGET);
    end

    settle();
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
